@@ rtl/decimal_timestamp_parser_assert.svh @@
// Assertion macros shared by the timestamp parser modules.
// Needs nothing else; each macro takes a label, clock, active-low reset and two expressions.
`ifndef DECIMAL_TIMESTAMP_PARSER_ASSERT_SVH
`define DECIMAL_TIMESTAMP_PARSER_ASSERT_SVH

// Same-cycle implication.
`define DTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timestamp parser assertion failed");

// Next-cycle implication.
`define DTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timestamp parser assertion failed");

`endif

@@ rtl/dtp_pkg.sv @@
// Shared types and constants for the decimal timestamp parser.
// No dependencies; used by dtp_front, dtp_queue, dtp_back and the top level.
package dtp_pkg;

    localparam int unsigned FRAC_DIGITS     = 9;
    localparam int unsigned DTP_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_POINT,
        KIND_BAD
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_CHAR,
        ST_SECOND_POINT,
        ST_LONG_FRACTION,
        ST_TOO_SHORT
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_tok;

endpackage

@@ rtl/decimal_timestamp_parser.sv @@
// Decimal timestamp parser: one ASCII character per push beat, one result beat per text
// (on the character marked last), giving seconds, nanoseconds and a status. A character can
// be pushed every cycle while full is low; a result reaches the output ports through the
// front register, the token queue and the result register. full rises only while a
// finished result waits unpopped and the token queue and front register have filled
// behind it.
// Depends on dtp_pkg, dtp_front, dtp_queue and dtp_back.
module decimal_timestamp_parser
    import dtp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DTP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_seconds,
    output logic [29:0] o_nanoseconds,
    output logic [2:0]  o_status
);

    logic    front_valid;
    t_tok    front_tok;
    logic    q_full;
    logic    q_valid;
    t_tok    q_tok;
    logic    q_take;
    t_status status;

    dtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_q_full    (q_full)
    );

    dtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_tok   (front_tok),
        .o_full     (q_full),
        .o_rd_valid (q_valid),
        .o_rd_tok   (q_tok),
        .i_rd_take  (q_take)
    );

    dtp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (q_valid),
        .i_tok         (q_tok),
        .o_tok_take    (q_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_seconds     (o_seconds),
        .o_nanoseconds (o_nanoseconds),
        .o_status      (status)
    );

    assign o_status = status;

endmodule

@@ rtl/dtp_front.sv @@
// Front end: accepts one character beat per cycle while o_full is low and classifies it into a token.
// Depends on dtp_pkg; feeds dtp_queue.
module dtp_front
    import dtp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_tok_valid,
    output t_tok       o_tok,
    input  logic       i_q_full
);

    logic r_valid;
    logic n_valid;
    t_tok r_tok;
    t_tok cls_tok;
    logic accept;

    always_comb begin
        cls_tok.digit = i_char_code[3:0];
        cls_tok.last  = i_last_char;
        if (i_char_code == CHAR_POINT) begin
            cls_tok.kind = KIND_POINT;
        end else if (i_char_code >= CHAR_ZERO && i_char_code <= CHAR_NINE) begin
            cls_tok.kind = KIND_DIGIT;
        end else begin
            cls_tok.kind = KIND_BAD;
        end
    end

    assign o_full      = r_valid && i_q_full;
    assign accept      = i_push && !o_full;
    assign n_valid     = accept || (r_valid && i_q_full);
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok <= cls_tok;
        end
    end

endmodule

@@ rtl/dtp_queue.sv @@
// Short token queue between the front end and the back end.
// Depends on dtp_pkg for the token type.
`include "decimal_timestamp_parser_assert.svh"
module dtp_queue
    import dtp_pkg::*;
#(
    parameter int unsigned DEPTH = DTP_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    input  t_tok i_wr_tok,
    output logic o_full,
    output logic o_rd_valid,
    output t_tok o_rd_tok,
    input  logic i_rd_take
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_tok             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             wr;
    logic             rd;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_tok   = r_mem[r_rd_ptr];
    assign wr         = i_wr_valid && !o_full;
    assign rd         = i_rd_take && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_tok;
        end
    end

    `DTP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DTP_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, wr && !rd, r_count == $past(r_count) + 1'b1)

endmodule

@@ rtl/dtp_back.sv @@
// Back end: runs the seconds/nanoseconds accumulators over tokens and holds the result beat.
// Depends on dtp_pkg; reads tokens from dtp_queue.
`include "decimal_timestamp_parser_assert.svh"
module dtp_back
    import dtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    input  t_tok        i_tok,
    output logic        o_tok_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_seconds,
    output logic [29:0] o_nanoseconds,
    output t_status     o_status
);

    localparam logic [29:0] NSEC_LIMIT = 30'd1000000000;

    function automatic logic [31:0] sat_push(input logic [31:0] acc, input logic [3:0] dig);
        logic [35:0] v;
        v = 36'({acc, 3'b000}) + 36'({acc, 1'b0}) + 36'(dig);
        return (v[35:32] != 4'd0) ? '1 : v[31:0];
    endfunction

    // weight of the next fraction digit: 10^(8-idx)
    function automatic logic [26:0] frac_weight(input logic [3:0] idx);
        logic [26:0] w;
        case (idx)
            4'd0:    w = 27'd100000000;
            4'd1:    w = 27'd10000000;
            4'd2:    w = 27'd1000000;
            4'd3:    w = 27'd100000;
            4'd4:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = 27'd0;
        endcase
        return w;
    endfunction

    function automatic logic [29:0] lead_weight(input logic [3:0] k);
        logic [29:0] w;
        case (k)
            4'd1:    w = 30'd100000000;
            4'd2:    w = 30'd200000000;
            4'd3:    w = 30'd300000000;
            4'd4:    w = 30'd400000000;
            4'd5:    w = 30'd500000000;
            4'd6:    w = 30'd600000000;
            4'd7:    w = 30'd700000000;
            4'd8:    w = 30'd800000000;
            4'd9:    w = 30'd900000000;
            default: w = 30'd0;
        endcase
        return w;
    endfunction

    logic [31:0]                 r_int,    n_int;
    logic [31:0]                 r_high,   n_high;
    logic [29:0]                 r_low,    n_low;
    logic [3:0]                  r_wcnt,   n_wcnt;
    logic [29:0]                 r_frac,   n_frac;
    logic [3:0]                  r_fcnt,   n_fcnt;
    logic                        r_point,  n_point;
    t_status                     r_err,    n_err;
    logic [FRAC_DIGITS-1:0][3:0] r_digits, n_digits;

    logic        r_res_valid, n_res_valid;
    logic [31:0] r_sec,       n_sec;
    logic [29:0] r_nsec,      n_nsec;
    t_status     r_status,    n_status;

    logic        take;
    logic [3:0]  d;
    logic [3:0]  lead;
    logic [29:0] rem;
    logic [33:0] low_grow;
    logic [33:0] low_roll;
    logic [30:0] frac_add;
    logic [30:0] frac_sum;

    assign take       = i_tok_valid && (!i_tok.last || !r_res_valid || i_pop);
    assign o_tok_take = take;
    assign d          = i_tok.digit;
    assign lead       = r_digits[FRAC_DIGITS-1];
    assign rem        = r_low - lead_weight(lead);
    assign low_grow   = 34'({r_low, 3'b000}) + 34'({r_low, 1'b0}) + 34'(d);
    assign low_roll   = 34'({rem, 3'b000}) + 34'({rem, 1'b0}) + 34'(d);
    assign frac_add   = 31'(d) * 31'(frac_weight(r_fcnt));
    assign frac_sum   = 31'(r_frac) + frac_add;

    always_comb begin
        n_int       = r_int;
        n_high      = r_high;
        n_low       = r_low;
        n_wcnt      = r_wcnt;
        n_frac      = r_frac;
        n_fcnt      = r_fcnt;
        n_point     = r_point;
        n_err       = r_err;
        n_digits    = r_digits;
        n_res_valid = r_res_valid && !i_pop;
        n_sec       = r_sec;
        n_nsec      = r_nsec;
        n_status    = r_status;
        if (take) begin
            if (r_err == ST_OK) begin
                unique case (i_tok.kind)
                    KIND_POINT: begin
                        if (r_point) begin
                            n_err = ST_SECOND_POINT;
                        end else begin
                            n_point = 1'b1;
                        end
                    end
                    KIND_DIGIT: begin
                        if (r_point) begin
                            if (r_fcnt >= 4'(FRAC_DIGITS)) begin
                                n_err  = ST_LONG_FRACTION;
                                n_fcnt = 4'(FRAC_DIGITS + 1);
                            end else begin
                                n_frac = frac_sum[29:0];
                                n_fcnt = r_fcnt + 4'd1;
                            end
                        end else begin
                            n_int    = sat_push(r_int, d);
                            n_digits = {r_digits[FRAC_DIGITS-2:0], d};
                            if (r_wcnt >= 4'(FRAC_DIGITS)) begin
                                n_high = sat_push(r_high, lead);
                                n_low  = low_roll[29:0];
                            end else begin
                                n_low  = low_grow[29:0];
                                n_wcnt = r_wcnt + 4'd1;
                            end
                        end
                    end
                    default: begin
                        n_err = ST_BAD_CHAR;
                    end
                endcase
            end
            if (i_tok.last) begin
                n_res_valid = 1'b1;
                n_status    = n_err;
                n_sec       = '0;
                n_nsec      = '0;
                if (n_err == ST_OK) begin
                    if (n_point) begin
                        n_sec  = n_int;
                        n_nsec = n_frac;
                    end else if (n_wcnt < 4'(FRAC_DIGITS)) begin
                        n_status = ST_TOO_SHORT;
                    end else begin
                        n_sec  = n_high;
                        n_nsec = n_low;
                    end
                end
                n_int   = '0;
                n_high  = '0;
                n_low   = '0;
                n_wcnt  = '0;
                n_frac  = '0;
                n_fcnt  = '0;
                n_point = 1'b0;
                n_err   = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int       <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_wcnt      <= '0;
            r_frac      <= '0;
            r_fcnt      <= '0;
            r_point     <= 1'b0;
            r_err       <= ST_OK;
            r_res_valid <= 1'b0;
        end else begin
            r_int       <= n_int;
            r_high      <= n_high;
            r_low       <= n_low;
            r_wcnt      <= n_wcnt;
            r_frac      <= n_frac;
            r_fcnt      <= n_fcnt;
            r_point     <= n_point;
            r_err       <= n_err;
            r_res_valid <= n_res_valid;
        end
    end

    // window digits and result payload
    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_sec    <= n_sec;
        r_nsec   <= n_nsec;
        r_status <= n_status;
    end

    assign o_empty       = !r_res_valid;
    assign o_seconds     = r_sec;
    assign o_nanoseconds = r_nsec;
    assign o_status      = r_status;

    `DTP_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_res_valid && r_status != ST_OK,
        r_sec == '0 && r_nsec == '0)
    `DTP_ASSERT_NOW(a_nsec_range, i_clk, i_rst_n, r_res_valid, r_nsec < NSEC_LIMIT)
    `DTP_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, take && i_tok.last,
        r_wcnt == '0 && r_fcnt == '0 && !r_point && r_err == ST_OK && r_res_valid)

endmodule

@@ verif/tb_top.sv @@
// Testbench for decimal_timestamp_parser: streams timestamp texts, one character per beat,
// and checks each result beat against an in-bench model of the parser.
// Depends on dtp_pkg and the decimal_timestamp_parser RTL.
module tb_top;
    import dtp_pkg::*;

    localparam int unsigned N_ITEMS        = 1250;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [31:0] SEC_SAT        = 32'hFFFF_FFFF;

    typedef enum int unsigned {
        TXT_POINT,
        TXT_WHOLE,
        TXT_SHORT,
        TXT_LONG_FRAC,
        TXT_BROKEN,
        TXT_JUNK
    } t_text_kind;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       drain;
    } t_char_beat;

    typedef struct packed {
        logic [31:0] seconds;
        logic [29:0] nanos;
        t_status     status;
    } t_stamp;

    typedef logic [7:0] t_text[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_code = '0;
    logic        i_last_char = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_seconds;
    logic [29:0] o_nanoseconds;
    logic [2:0]  o_status;

    t_char_beat  char_q[$];
    t_stamp      stamp_q[$];

    // parser model state
    logic [31:0] whole_sec;
    logic [31:0] high_sec;
    logic [29:0] ns_window;
    logic [3:0]  window_len;
    logic [29:0] frac_val;
    logic [3:0]  frac_len;
    logic        point_seen;
    t_status     first_err;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int unsigned pat_age = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_texts = 0;
    int unsigned n_chars = 0;
    int unsigned n_directed = 0;
    int unsigned n_results = 0;
    int unsigned n_err = 0;
    int unsigned n_sat = 0;
    int unsigned n_status [5] = '{default: 0};

    decimal_timestamp_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .empty         (empty),
        .pop           (pop),
        .o_seconds     (o_seconds),
        .o_nanoseconds (o_nanoseconds),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] push_digit_sat(logic [31:0] acc, logic [3:0] d);
        logic [35:0] v;
        v = {4'd0, acc} * 36'd10 + {32'd0, d};
        return (v > {4'd0, SEC_SAT}) ? SEC_SAT : v[31:0];
    endfunction

    function automatic logic [31:0] ten_pow(int unsigned k);
        logic [31:0] p;
        p = 32'd1;
        for (int unsigned i = 0; i < k; i++) p = p * 32'd10;
        return p;
    endfunction

    task automatic clear_parse();
        whole_sec  = '0;
        high_sec   = '0;
        ns_window  = '0;
        window_len = '0;
        frac_val   = '0;
        frac_len   = '0;
        point_seen = 1'b0;
        first_err  = ST_OK;
    endtask

    task automatic parse_char(logic [7:0] code, logic last);
        logic [3:0]  d;
        logic [31:0] top;
        t_stamp      s;
        d = 4'(code - CHAR_ZERO);
        top = ten_pow(FRAC_DIGITS - 1);
        if (first_err == ST_OK) begin
            if (code == CHAR_POINT) begin
                if (point_seen) first_err = ST_SECOND_POINT;
                else point_seen = 1'b1;
            end else if (code < CHAR_ZERO || code > CHAR_NINE) begin
                first_err = ST_BAD_CHAR;
            end else if (point_seen) begin
                if (frac_len >= FRAC_DIGITS) begin
                    first_err = ST_LONG_FRACTION;
                end else begin
                    frac_val = frac_val * 30'd10 + 30'(d);
                    frac_len = frac_len + 4'd1;
                end
            end else begin
                whole_sec = push_digit_sat(whole_sec, d);
                if (window_len >= FRAC_DIGITS) begin
                    // leading window digit moves into the seconds
                    high_sec = push_digit_sat(high_sec, 4'(32'(ns_window) / top));
                    ns_window = 30'((32'(ns_window) % top) * 32'd10 + 32'(d));
                end else begin
                    ns_window = ns_window * 30'd10 + 30'(d);
                    window_len = window_len + 4'd1;
                end
            end
        end
        if (last) begin
            s.seconds = '0;
            s.nanos   = '0;
            s.status  = first_err;
            if (first_err == ST_OK) begin
                if (point_seen) begin
                    s.seconds = whole_sec;
                    s.nanos   = 30'(32'(frac_val) * ten_pow(FRAC_DIGITS - frac_len));
                end else if (window_len < FRAC_DIGITS) begin
                    s.status = ST_TOO_SHORT;
                end else begin
                    s.seconds = high_sec;
                    s.nanos   = ns_window;
                end
            end
            stamp_q = {stamp_q, s};
            n_status[s.status]++;
            if (s.seconds == SEC_SAT) n_sat++;
            clear_parse();
        end
    endtask

    function automatic logic [7:0] rand_bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_POINT);
        return c;
    endfunction

    task automatic add_digits(ref t_text txt, input int unsigned n, input bit nines);
        logic [7:0] c;
        repeat (n) begin
            c = nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(0, 9));
            txt = {txt, c};
        end
    endtask

    task automatic add_text(t_text txt, logic drain);
        t_char_beat b;
        foreach (txt[i]) begin
            b.code  = txt[i];
            b.last  = (i == txt.size() - 1);
            b.drain = drain && (i == 0);
            char_q = {char_q, b};
        end
        n_texts++;
    endtask

    task automatic make_text(t_text_kind kind, output t_text txt);
        bit          nines;
        int unsigned n;
        int unsigned pos;
        txt = {};
        nines = ($urandom_range(0, 4) == 0);
        case (kind)
            TXT_POINT: begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 10);
                add_digits(txt, n, nines);
                txt = {txt, CHAR_POINT};
                add_digits(txt, $urandom_range(0, FRAC_DIGITS), nines);
            end
            TXT_WHOLE: begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(9, 12);
                add_digits(txt, n, nines);
            end
            TXT_SHORT: begin
                add_digits(txt, $urandom_range(1, FRAC_DIGITS - 1), nines);
            end
            TXT_LONG_FRAC: begin
                add_digits(txt, $urandom_range(0, 3), nines);
                txt = {txt, CHAR_POINT};
                add_digits(txt, $urandom_range(FRAC_DIGITS + 1, FRAC_DIGITS + 4), nines);
            end
            TXT_BROKEN: begin
                add_digits(txt, $urandom_range(1, 12), nines);
                if ($urandom_range(0, 1) == 1) begin
                    txt = {txt, CHAR_POINT};
                    add_digits(txt, $urandom_range(0, FRAC_DIGITS), nines);
                end
                pos = $urandom_range(0, txt.size() - 1);
                txt[pos] = ($urandom_range(0, 1) == 1) ? CHAR_POINT : rand_bad_char();
            end
            default: begin
                repeat ($urandom_range(1, 6)) txt = {txt, 8'($urandom_range(0, 255))};
            end
        endcase
    endtask

    always @(posedge i_clk) begin : driver
        logic go;
        go = 1'b0;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_char(i_char_code, i_last_char);
                void'(char_q.pop_front());
            end
            if (gap_left != 0) begin
                gap_left--;
            end else if (char_q.size() != 0 && !(char_q[0].drain && stamp_q.size() != 0)) begin
                go = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
            push <= go;
            if (go) begin
                i_char_code <= char_q[0].code;
                i_last_char <= char_q[0].last;
            end else begin
                i_char_code <= 8'($urandom);
                i_last_char <= 1'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_stamp      want;
        logic [15:0] pat;
        pat = stall_pat;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (stamp_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("unexpected result beat: sec=%0d ns=%0d status=%0d",
                                 o_seconds, o_nanoseconds, o_status);
                end else begin
                    want = stamp_q.pop_front();
                    if (o_seconds !== want.seconds || o_nanoseconds !== want.nanos ||
                            o_status !== want.status) begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display({"result %0d: expected sec=%0d ns=%0d status=%0d,",
                                      " got sec=%0d ns=%0d status=%0d"},
                                     n_results, want.seconds, want.nanos, want.status,
                                     o_seconds, o_nanoseconds, o_status);
                    end
                end
            end
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = 16'hFFFF;
                    1: pat = 16'($urandom) | 16'h0001;
                    2: pat = 16'($urandom & $urandom) | 16'h0001;
                    default: pat = 16'($urandom | $urandom) | 16'h0001;
                endcase
                pat_age = 48;
            end
            pat_age--;
            pop <= pat[0];
            stall_pat <= {pat[0], pat[15:1]};
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d characters and %0d results pending",
                     idle_cycles, char_q.size(), stamp_q.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_text      t;
        t_text_kind kind;
        int unsigned pick;
        bit          mid_done;
        mid_done = 1'b0;
        clear_parse();

        t = {CHAR_POINT};
        add_text(t, 1'b0);
        t = {8'hFF};
        add_text(t, 1'b0);
        t = {8'h00};
        add_text(t, 1'b0);
        t = {CHAR_ZERO - 8'd1, CHAR_NINE + 8'd1};
        add_text(t, 1'b0);
        t = {CHAR_POINT, CHAR_POINT, CHAR_ZERO + 8'd5};
        add_text(t, 1'b0);
        t = {CHAR_ZERO + 8'd5};
        add_text(t, 1'b0);
        t = {CHAR_NINE, CHAR_POINT};
        add_text(t, 1'b0);
        t = {CHAR_POINT};
        add_digits(t, FRAC_DIGITS + 1, 1'b1);
        add_text(t, 1'b0);
        n_directed = char_q.size();

        while (char_q.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) kind = TXT_POINT;
            else if (pick < 60) kind = TXT_WHOLE;
            else if (pick < 70) kind = TXT_SHORT;
            else if (pick < 80) kind = TXT_LONG_FRAC;
            else if (pick < 92) kind = TXT_BROKEN;
            else kind = TXT_JUNK;
            make_text(kind, t);
            // hold the sender until all results are out: at the start and midway
            if (char_q.size() == n_directed) begin
                add_text(t, 1'b1);
            end else if (!mid_done && char_q.size() >= N_ITEMS / 2) begin
                add_text(t, 1'b1);
                mid_done = 1'b1;
            end else begin
                add_text(t, 1'b0);
            end
        end
        n_chars = char_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (char_q.size() != 0 || push) @(posedge i_clk);
        while (stamp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d texts in %0d characters (%0d directed), %0d results, %0d saturated",
                 n_texts, n_chars, n_directed, n_results, n_sat);
        $display({"Status mix: ok %0d, bad char %0d, second point %0d, long fraction %0d,",
                  " too short %0d; mismatches %0d"},
                 n_status[ST_OK], n_status[ST_BAD_CHAR], n_status[ST_SECOND_POINT],
                 n_status[ST_LONG_FRACTION], n_status[ST_TOO_SHORT], n_err);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
